// File: rtl/ccrc_pkg.sv
// Shared types, register indexes and bit helpers for the configurable CRC engine.
package ccrc_pkg;

  localparam int unsigned CRC_MAX_W  = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [CFG_ADDR_W-1:0] CFG_CRC_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLY        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_VALUE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_XOR_OUT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFLECT_IN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFLECT_OUT = 3'd5;

  typedef struct packed {
    logic [5:0]           crc_width;
    logic [CRC_MAX_W-1:0] poly;
    logic [CRC_MAX_W-1:0] init_value;
    logic [CRC_MAX_W-1:0] xor_out;
    logic                 reflect_in;
    logic                 reflect_out;
  } ccrc_cfg_t;

  // Full 32-bit bit reversal; a reversal over w bits is this shifted right by 32-w.
  function automatic logic [CRC_MAX_W-1:0] rev32(input logic [CRC_MAX_W-1:0] v);
    logic [CRC_MAX_W-1:0] r;
    for (int i = 0; i < CRC_MAX_W; i++) begin
      r[i] = v[CRC_MAX_W-1-i];
    end
    return r;
  endfunction

  // Width clamped to 1..32.
  function automatic logic [5:0] eff_width(input logic [5:0] w);
    logic [5:0] e;
    if (w == 6'd0) begin
      e = 6'd1;
    end else if (w > 6'd32) begin
      e = 6'd32;
    end else begin
      e = w;
    end
    return e;
  endfunction

endpackage

// File: rtl/configurable_crc_engine.sv
// Top level of the configurable CRC engine: input register, CRC state and result register.
// A byte marked last is held in the input register, then its CRC is loaded into the result register for out_tvalid.
// Throughput: one byte per cycle, limited by the combinational eight-step xor network
// that updates the CRC register; it stalls only while a finished CRC is not taken.
// Reset: synchronous, active low; it clears the item and result valid flags, ends any
// message in progress and loads the register defaults (width 8, polynomial 0x07).
module configurable_crc_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel. in_tdata: [7:0] data_byte. in_tlast: last_byte.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  input  logic                                in_tlast,
  // Result channel. out_tdata: [31:0] crc_value.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ccrc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ccrc_pkg::CRC_MAX_W-1:0]      cfg_wdata
);
  import ccrc_pkg::*;

  ccrc_cfg_t cfg;

  // Input register stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Running CRC state; mid_r is set while a message is in progress.
  logic [CRC_MAX_W-1:0] crc_r;
  logic                 mid_r;

  // Result register.
  logic                 out_valid_r;
  logic [CRC_MAX_W-1:0] out_crc_r;

  logic [CRC_MAX_W-1:0] crc_nxt;
  logic [CRC_MAX_W-1:0] crc_fin;
  logic                 s1_adv;
  logic                 in_fire;

  ccrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The preset is taken from the current registers at the first byte of a message,
  // so configuration written between messages takes effect on the next one.
  ccrc_byte_update u_update (
    .cfg       (cfg),
    .start     (!mid_r),
    .crc_in    (crc_r),
    .data_byte (s1_byte_r),
    .crc_nxt   (crc_nxt),
    .crc_fin   (crc_fin)
  );

  // A byte that is not last always moves on; a last byte needs the result
  // register to be free or emptied in this same cycle.
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (s1_adv) begin
      mid_r <= !s1_last_r;
    end
  end

  // After a last byte the stored value is unused: the next byte reloads the preset.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_crc_r <= crc_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_crc_r;

  // A finished last byte always lands in the result register.
  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r)
    else $error("last byte did not produce a result");

  // A byte that is not last leaves a message in progress.
  a_mid_after_body: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_last_r |=> mid_r)
    else $error("message state lost after a body byte");

  // A blocked last byte holds off new input.
  a_block_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted while a last byte was blocked");

  // A waiting result is not overwritten.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_crc_r))
    else $error("pending result changed");

endmodule

// File: rtl/ccrc_cfg_regs.sv
// Configuration register file of the configurable CRC engine.
module ccrc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ccrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ccrc_pkg::CRC_MAX_W-1:0]       cfg_wdata,
  output ccrc_pkg::ccrc_cfg_t                  cfg
);
  import ccrc_pkg::*;

  ccrc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_width   <= 6'd8;
      cfg_r.poly        <= 32'h0000_0007;
      cfg_r.init_value  <= '0;
      cfg_r.xor_out     <= '0;
      cfg_r.reflect_in  <= 1'b0;
      cfg_r.reflect_out <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CRC_WIDTH:   cfg_r.crc_width   <= cfg_wdata[5:0];
        CFG_POLY:        cfg_r.poly        <= cfg_wdata;
        CFG_INIT_VALUE:  cfg_r.init_value  <= cfg_wdata;
        CFG_XOR_OUT:     cfg_r.xor_out     <= cfg_wdata;
        CFG_REFLECT_IN:  cfg_r.reflect_in  <= cfg_wdata[0];
        CFG_REFLECT_OUT: cfg_r.reflect_out <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/ccrc_byte_update.sv
// Combinational one-byte CRC update and finishing logic.
module ccrc_byte_update (
  input  ccrc_pkg::ccrc_cfg_t                 cfg,
  input  logic                                start,
  input  logic [ccrc_pkg::CRC_MAX_W-1:0]      crc_in,
  input  logic [ccrc_pkg::BYTE_W-1:0]         data_byte,
  output logic [ccrc_pkg::CRC_MAX_W-1:0]      crc_nxt,
  output logic [ccrc_pkg::CRC_MAX_W-1:0]      crc_fin
);
  import ccrc_pkg::*;

  logic [5:0]           w;
  logic [4:0]           sh;
  logic [CRC_MAX_W-1:0] mask;
  logic [CRC_MAX_W-1:0] p;
  logic [CRC_MAX_W-1:0] preset;
  logic [CRC_MAX_W-1:0] base;
  logic [CRC_MAX_W-1:0] acc;
  logic [CRC_MAX_W-1:0] fin;

  always_comb begin
    w    = eff_width(cfg.crc_width);
    sh   = 5'(6'd32 - w);
    mask = {CRC_MAX_W{1'b1}} >> sh;
    p    = cfg.poly & mask;

    preset = cfg.init_value & mask;
    if (cfg.reflect_in) begin
      preset = rev32(preset) >> sh;
    end
    base = (start ? preset : crc_in) & mask;

    if (cfg.reflect_in) begin
      // Register held right-aligned and reflected; feedback from bit 0.
      acc = base;
      for (int b = 0; b < BYTE_W; b++) begin
        if (acc[0] ^ data_byte[b]) begin
          acc = (acc >> 1) ^ (rev32(p) >> sh);
        end else begin
          acc = acc >> 1;
        end
      end
    end else begin
      // Register left-aligned so the feedback bit is always bit 31.
      acc = base << sh;
      for (int b = BYTE_W - 1; b >= 0; b--) begin
        if (acc[CRC_MAX_W-1] ^ data_byte[b]) begin
          acc = (acc << 1) ^ (p << sh);
        end else begin
          acc = acc << 1;
        end
      end
      acc = acc >> sh;
    end
    crc_nxt = acc & mask;

    fin = crc_nxt;
    if (cfg.reflect_in != cfg.reflect_out) begin
      fin = rev32(crc_nxt) >> sh;
    end
    crc_fin = (fin ^ cfg.xor_out) & mask;
  end

endmodule

// File: test/tb_configurable_crc_engine.sv
// Self-checking testbench for the configurable CRC engine: directed and random byte messages.
module tb_configurable_crc_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ccrc_pkg::*;

  // A last byte's CRC passes the input register and then the result register. The settle
  // pause adds margin so that the block is surely idle before a register write.
  localparam int RESULT_LATENCY = 2;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;
  // The slowest correct run is roughly 1200 items with sender gaps and receiver stalls;
  // the limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PRINT_CAP      = 200;

  // Clock, reset and every DUT input start at a known value.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic        in_tlast   = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] crc_value
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CRC_MAX_W-1:0]  cfg_wdata = '0;

  configurable_crc_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Our own copy of the register file, starting from the documented reset values.
  logic [5:0]  set_width  = 6'd8;
  logic [31:0] set_poly   = 32'h0000_0007;
  logic [31:0] set_init   = '0;
  logic [31:0] set_xorout = '0;
  logic        set_refin  = 1'b0;
  logic        set_refout = 1'b0;

  // Running CRC and whether a message is open. The reset preset is zero for the
  // reset settings, and the first byte reloads it anyway.
  logic [31:0] crc_state = '0;
  logic        msg_open  = 1'b0;

  // CRCs that finished messages are expected to produce, oldest first.
  logic [31:0] pending_crcs[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // CRC predictor
  // ---------------------------------------------------------------------------

  // A width of zero behaves as one bit, anything above 32 as 32 bits.
  function automatic int unsigned used_width();
    if (set_width == 6'd0) return 1;
    if (set_width > 6'd32) return 32;
    return int'(set_width);
  endfunction

  function automatic logic [31:0] width_ones(int unsigned w);
    return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
  endfunction

  // Mirror the low w bits of v; higher bits drop out.
  function automatic logic [31:0] reverse_bits(logic [31:0] v, int unsigned w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < w && v[i]) begin
        r[w-1-i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Preset for a new message: init value masked to width, mirrored in reflected mode.
  function automatic logic [31:0] start_value();
    int unsigned w;
    logic [31:0] v;
    w = used_width();
    v = set_init & width_ones(w);
    return set_refin ? reverse_bits(v, w) : v;
  endfunction

  // Advance the predicted CRC by one accepted byte and queue the CRC on a last byte.
  // The registers are read on every byte, so a change mid-message mixes settings.
  function automatic void track_byte(logic [7:0] data, logic last);
    int unsigned w;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] c;
    logic        fb;
    w = used_width();
    m = width_ones(w);
    p = set_poly & m;
    if (!msg_open) begin
      crc_state = start_value();
      msg_open  = 1'b1;
    end
    c = crc_state & m;
    if (set_refin) begin
      // Reflected form: LSB of the byte first, register shifts right.
      p = reverse_bits(p, w);
      for (int b = 0; b < 8; b++) begin
        fb = c[0] ^ data[b];
        c  = c >> 1;
        if (fb) c = c ^ p;
      end
    end else begin
      // Normal form: MSB first, the register top bit sits at w-1.
      for (int b = 7; b >= 0; b--) begin
        fb = c[w-1] ^ data[b];
        c  = (c << 1) & m;
        if (fb) c = c ^ p;
      end
    end
    c = c & m;
    crc_state = c;
    if (last) begin
      if (set_refout != set_refin) c = reverse_bits(c, w);
      c = (c ^ set_xorout) & m;
      pending_crcs.push_back(c);
      msg_open  = 1'b0;
      crc_state = start_value();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  task automatic flag_error(string what);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Offer one item and hold it until the DUT takes it. The caller is at a rising edge.
  // Valid stays high on return so back-to-back items never toggle it within one step.
  task automatic send_item(logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!in_tready);
    track_byte(data, last);
  endtask

  // Drop valid, wait for every expected CRC, then let the pipeline settle. A message may
  // still be open here, in which case the last accepted byte is still in flight.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. The enable is raised at a rising edge and falls once the DUT has sampled it.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (addr)
      CFG_CRC_WIDTH:   set_width  = data[5:0];
      CFG_POLY:        set_poly   = data;
      CFG_INIT_VALUE:  set_init   = data;
      CFG_XOR_OUT:     set_xorout = data;
      CFG_REFLECT_IN:  set_refin  = data[0];
      CFG_REFLECT_OUT: set_refout = data[0];
      default: ;
    endcase
  endtask

  task automatic program_crc(logic [31:0] w, logic [31:0] poly, logic [31:0] init,
                             logic [31:0] xo, logic [31:0] ri, logic [31:0] ro);
    write_reg(CFG_CRC_WIDTH,   w);
    write_reg(CFG_POLY,        poly);
    write_reg(CFG_INIT_VALUE,  init);
    write_reg(CFG_XOR_OUT,     xo);
    write_reg(CFG_REFLECT_IN,  ri);
    write_reg(CFG_REFLECT_OUT, ro);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------

  // Samples at the rising edge, so values seen are those the DUT saw at that edge.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_crcs.size() == 0) begin
        flag_error($sformatf("unexpected CRC 0x%08h", out_tdata));
      end else begin
        want = pending_crcs.pop_front();
        if (out_tdata !== want) begin
          flag_error($sformatf("crc_value 0x%08h, expected 0x%08h", out_tdata, want));
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No register written yet: the reset settings (8 bits, polynomial 0x07) must hold.
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    wait_idle();
  endtask

  // Fully reflected 32-bit CRC over the usual check string, all-ones preset and xor.
  task automatic test_standard_crc32();
    program_crc(32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
    for (int i = 1; i <= 9; i++) begin
      send_item(8'h30 + 8'(i), i == 9);
    end
    wait_idle();
  endtask

  // Width 0 behaves as 1, width 1 is plain parity, and 63 behaves as 32. Upper bits of
  // the write data beyond the width field are set to show they are dropped.
  task automatic test_width_limits();
    program_crc(32'hFFFF_FFC0, 32'h1, 32'h0, 32'h0, 0, 0);
    send_item(8'h80, 1'b1);
    wait_idle();
    program_crc(1, 32'h1, 32'h1, 32'h1, 0, 0);
    send_item(8'h7F, 1'b1);
    wait_idle();
    program_crc(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 0);
    send_item(8'h01, 1'b1);
    wait_idle();
  endtask

  // Input and output reflection disagree, so the finished register is mirrored.
  task automatic test_reflect_mismatch();
    program_crc(16, 32'h8005, 32'h0000, 32'h0000, 1, 0);
    send_item(8'hA5, 1'b1);
    wait_idle();
    program_crc(12, 32'h80F, 32'h123, 32'hABC, 0, 1);
    send_item(8'h5A, 1'b1);
    wait_idle();
  endtask

  // Polynomial, preset and xor carry bits above the width that must be ignored.
  task automatic test_wide_operands();
    program_crc(5, 32'hFFFF_FFF5, 32'hFFFF_FFE3, 32'hA5A5_A5B1, 0, 0);
    send_item(8'hC3, 1'b1);
    wait_idle();
    write_reg(CFG_REFLECT_IN, 32'hFFFF_FFFF);
    send_item(8'h3C, 1'b1);
    wait_idle();
  endtask

  // Registers rewritten while a message is open. A new preset only matters for the
  // next message; polynomial and xor take effect on the following byte.
  task automatic test_mid_message_change();
    program_crc(16, 32'h1021, 32'hFFFF, 32'h0000, 0, 0);
    send_item(8'h12, 1'b0);
    wait_idle();
    write_reg(CFG_POLY,       32'h8005);
    write_reg(CFG_XOR_OUT,    32'h5555);
    write_reg(CFG_INIT_VALUE, 32'h1D0F);
    send_item(8'h34, 1'b1);
    send_item(8'h56, 1'b1);
    wait_idle();
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random settings per round, with the first two rounds of each idling mode at the
  // extremes; then random messages that are mostly short and sometimes long.
  task automatic test_random_traffic();
    int send_pct[4]  = '{0, 83, 0, 8};
    int stall_pct[4] = '{0, 0, 83, 8};
    int items;
    int len;
    logic [31:0] w;
    logic [7:0]  data;
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct  = send_pct[mode];
      recv_stall_pct = stall_pct[mode];
      for (int round = 0; round < 6; round++) begin
        if (round == 0) begin
          program_crc(1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'(mode[0]), 32'(mode[1]));
        end else if (round == 1) begin
          program_crc(32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                      32'(mode[1]), 32'(mode[0]));
        end else begin
          case ($urandom_range(4))
            0:       w = 32'($urandom_range(63));
            1:       w = 32;
            default: w = 32'($urandom_range(1, 32));
          endcase
          if ($urandom_range(3) == 0) w = ($urandom & 32'hFFFF_FFC0) | w;
          program_crc(w, pick_word(), pick_word(), pick_word(),
                      $urandom_range(1) ? $urandom : 32'($urandom_range(1)),
                      $urandom_range(1) ? $urandom : 32'($urandom_range(1)));
        end
        items = 0;
        while (items < 46) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
              0:       data = 8'h00;
              1:       data = 8'hFF;
              default: data = 8'($urandom);
            endcase
            send_item(data, i == len - 1);
          end
          items += len;
        end
        wait_idle();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_standard_crc32();
    test_width_limits();
    test_reflect_mismatch();
    test_wide_operands();
    test_mid_message_change();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
